>>> hdl/tlfr_pkg.sv
// Shared constants and types for the two-length frame receiver.
// Used by tlfr_frame_ctl and two_length_frame_receiver; no dependencies.
package tlfr_pkg;

  localparam int LONG_PAYLOAD  = 5;
  localparam int SHORT_PAYLOAD = 3;

  localparam int POS_W  = $clog2(LONG_PAYLOAD + 3);
  localparam int ADDR_W = (LONG_PAYLOAD > 1) ? $clog2(LONG_PAYLOAD) : 1;

  localparam logic [7:0] START_MARK     = 8'hAA;
  localparam logic [7:0] LONG_END_MARK  = 8'hBB;
  localparam logic [7:0] SHORT_END_MARK = 8'hCC;

  localparam logic KIND_LONG  = 1'b0;
  localparam logic KIND_SHORT = 1'b1;

  localparam logic [POS_W-1:0] POS_IDLE        = '0;
  localparam logic [POS_W-1:0] POS_FIRST       = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST_STORE  = POS_W'(LONG_PAYLOAD);
  localparam logic [POS_W-1:0] POS_SHORT_END   = POS_W'(SHORT_PAYLOAD + 2);
  localparam logic [POS_W-1:0] POS_LONG_END    = POS_W'(LONG_PAYLOAD + 2);

  localparam logic [ADDR_W-1:0] SHORT_END_ADDR = ADDR_W'(SHORT_PAYLOAD - 1);
  localparam logic [ADDR_W-1:0] LONG_END_ADDR  = ADDR_W'(LONG_PAYLOAD - 1);

  typedef struct packed {
    logic              start;
    logic              kind;
    logic [ADDR_W-1:0] end_addr;
  } emit_t;

endpackage

>>> hdl/tlfr_frame_ctl.sv
// Frame position tracker: hunts the start mark, addresses payload writes and
// decides when a short or long frame completes. Depends on tlfr_pkg.
module tlfr_frame_ctl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 rx_byte,
  output logic                       wr_en,
  output logic [tlfr_pkg::ADDR_W-1:0] wr_addr,
  output tlfr_pkg::emit_t            emit
);
  import tlfr_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] pos_dec;

  assign pos_inc = pos + POS_W'(1);
  assign pos_dec = pos - POS_W'(1);
  assign wr_addr = pos_dec[ADDR_W-1:0];

  always_comb begin
    pos_next      = pos;
    wr_en         = 1'b0;
    emit.start    = 1'b0;
    emit.kind     = KIND_LONG;
    emit.end_addr = LONG_END_ADDR;
    if (accept) begin
      if (pos == POS_IDLE) begin
        if (rx_byte == START_MARK) begin
          pos_next = POS_FIRST;
        end
      end else begin
        wr_en = (pos <= POS_LAST_STORE);
        priority if (pos_inc == POS_SHORT_END && rx_byte == SHORT_END_MARK) begin
          pos_next      = POS_IDLE;
          emit.start    = 1'b1;
          emit.kind     = KIND_SHORT;
          emit.end_addr = SHORT_END_ADDR;
        end else if (pos_inc >= POS_LONG_END) begin
          pos_next   = POS_IDLE;
          emit.start = (rx_byte == LONG_END_MARK);
        end else begin
          pos_next = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

>>> hdl/two_length_frame_receiver.sv
// Top level of the two-length frame receiver: payload memory, unload
// sequencer and output register. Depends on tlfr_pkg and tlfr_frame_ctl.
//
//   port group  dir  payload                         transaction
//   s_*         in   tdata = rx_byte                 s_tvalid && s_tready
//   m_*         out  tdata = payload_byte,           m_tvalid && m_tready
//                    tuser = frame_kind, tlast = last_byte
//
// One received byte per cycle while collecting.
// A completed frame unloads from the payload memory one byte at a time: each read
// reaches mem_q, then the output register, before the next read issues; s_tready is
// low from the cycle after the terminator through the cycle after the last read.
// rst clears the frame position and the unload control; memory is not cleared.
// A stalled m_tready holds the output register and pauses the unload.
module two_length_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_byte
  output logic       m_tuser,   // [0] frame_kind
  output logic       m_tlast
);
  import tlfr_pkg::*;

  logic              accept;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  emit_t             emit;

  logic [7:0]        mem [LONG_PAYLOAD];
  logic [7:0]        mem_q;

  logic              draining;
  logic              rd_pend;
  logic              pend_last;
  logic              kind;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] end_addr;
  logic              issue;

  assign s_tready = !draining && !rd_pend;
  assign accept   = s_tvalid && s_tready;
  assign issue    = draining && !rd_pend && (!m_tvalid || m_tready);

  tlfr_frame_ctl u_ctl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s_tdata;
    end
    if (issue) begin
      mem_q     <= mem[rd_addr];
      pend_last <= (rd_addr == end_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit.start) begin
        draining <= 1'b1;
      end else if (issue && rd_addr == end_addr) begin
        draining <= 1'b0;
      end
      rd_pend <= issue;
      if (rd_pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.start) begin
      rd_addr  <= '0;
      end_addr <= emit.end_addr;
      kind     <= emit.kind;
    end else if (issue) begin
      rd_addr <= rd_addr + ADDR_W'(1);
    end
    if (rd_pend) begin
      m_tdata <= mem_q;
      m_tuser <= kind;
      m_tlast <= pend_last;
    end
  end

  a_emit_starts: assert property (@(posedge clk) disable iff (rst)
    emit.start |=> draining && rd_addr == '0)
    else $error("unload did not start at entry zero");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> m_tvalid && m_tdata == $past(mem_q))
    else $error("read data did not reach the output register");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    rd_pend && pend_last |-> !draining)
    else $error("unload still active after last read");

  a_no_write_in_unload: assert property (@(posedge clk) disable iff (rst)
    (draining || rd_pend) |-> !wr_en)
    else $error("payload write during unload");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for two_length_frame_receiver: queued byte stream in, payload beats checked
// against an in-bench deframer model. Depends on tlfr_pkg and the receiver RTL.
module tb;
  import tlfr_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } payload_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] rx_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] payload_byte
  logic       m_tuser;           // [0] frame_kind
  logic       m_tlast;

  two_length_frame_receiver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  logic [7:0]    byte_queue [$];
  payload_beat_t payload_due [$];
  int            bytes_total = 0;
  int            bytes_taken = 0;
  int            beats_seen = 0;
  int            mismatches = 0;
  bit            in_fire = 1'b0;
  bit            out_fire = 1'b0;

  // deframer state
  int         frame_pos = 0;
  logic [7:0] frame_bytes [LONG_PAYLOAD];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void emit_payload(input int count, input logic kind);
    payload_beat_t beat;
    for (int k = 0; k < count; k++) begin
      beat.kind = kind;
      beat.data = frame_bytes[k];
      beat.last = (k == count - 1);
      payload_due.push_back(beat);
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    if (frame_pos == 0) begin
      if (b == START_MARK) frame_pos = 1;
      return;
    end
    if (frame_pos <= LONG_PAYLOAD) frame_bytes[frame_pos - 1] = b;
    frame_pos++;
    if (frame_pos == SHORT_PAYLOAD + 2 && b == SHORT_END_MARK) begin
      frame_pos = 0;
      emit_payload(SHORT_PAYLOAD, KIND_SHORT);
      return;
    end
    if (frame_pos >= LONG_PAYLOAD + 2) begin
      frame_pos = 0;
      if (b == LONG_END_MARK) emit_payload(LONG_PAYLOAD, KIND_LONG);
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return START_MARK;
      1: return LONG_END_MARK;
      2: return SHORT_END_MARK;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // start mark, payload, terminator; a long payload never closes early as a short one
  task automatic queue_frame(input int n_payload, input logic [7:0] term, input bit fixed);
    logic [7:0] pattern [4];
    logic [7:0] b;
    pattern = '{8'h00, 8'hFF, START_MARK, SHORT_END_MARK};
    byte_queue.push_back(START_MARK);
    for (int k = 0; k < n_payload; k++) begin
      b = fixed ? pattern[k % 4] : pick_byte();
      if (n_payload > SHORT_PAYLOAD && k == SHORT_PAYLOAD && b == SHORT_END_MARK) b = ~b;
      byte_queue.push_back(b);
    end
    byte_queue.push_back(term);
  endtask

  function automatic logic [7:0] non_mark(input logic [7:0] mark);
    logic [7:0] b;
    b = pick_byte();
    return (b == mark) ? ~b : b;
  endfunction

  initial begin
    int pick;
    int n;
    // ignored while hunting, then short, long, and a dropped long frame
    byte_queue.push_back(8'h00);
    byte_queue.push_back(LONG_END_MARK);
    byte_queue.push_back(SHORT_END_MARK);
    queue_frame(SHORT_PAYLOAD, SHORT_END_MARK, 1'b1);
    queue_frame(LONG_PAYLOAD, LONG_END_MARK, 1'b1);
    queue_frame(LONG_PAYLOAD, SHORT_END_MARK, 1'b1);
    while (byte_queue.size() < 430) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) queue_frame(SHORT_PAYLOAD, SHORT_END_MARK, 1'b0);
      else if (pick < 75) queue_frame(LONG_PAYLOAD, LONG_END_MARK, 1'b0);
      else if (pick < 85) queue_frame(LONG_PAYLOAD, non_mark(LONG_END_MARK), 1'b0);
      else if (pick < 92) begin
        byte_queue.push_back(START_MARK);
        repeat (LONG_PAYLOAD + 1) byte_queue.push_back(pick_byte());
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) byte_queue.push_back(pick_byte());
      end
    end
    bytes_total = byte_queue.size();

    while (bytes_taken < bytes_total) @(posedge clk);
    while (payload_due.size() > 0) @(posedge clk);
    repeat (4 * LONG_PAYLOAD + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    payload_beat_t want;
    in_fire = !rst && s_tvalid && s_tready;
    out_fire = !rst && m_tvalid && m_tready;
    if (in_fire) begin
      bytes_taken++;
      deframe_byte(s_tdata);
    end
    if (out_fire) begin
      beats_seen++;
      if (payload_due.size() == 0) begin
        $error("unexpected transaction: payload_byte %02h", m_tdata);
        mismatches++;
      end else begin
        want = payload_due.pop_front();
        if (m_tuser !== want.kind) begin
          $error("frame_kind expected %0d actual %0d", want.kind, m_tuser);
          mismatches++;
        end
        if (m_tdata !== want.data) begin
          $error("payload_byte expected %02h actual %02h", want.data, m_tdata);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last_byte expected %0d actual %0d", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // byte driver
  int tx_gap = 0;
  bit tx_burst = 1'b0;
  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nd;
    nv = s_tvalid;
    nd = s_tdata;
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (in_fire) begin
        tx_gap = tx_burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        nv = 1'b0;
      end else if (byte_queue.size() > 0) begin
        nv = 1'b1;
        nd = byte_queue.pop_front();
      end else begin
        nv = 1'b0;
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
  end

  // payload sink; two long hold-offs back the block up into its input
  int rx_stall = 0;
  int rx_hold = 0;
  bit rx_burst = 1'b0;
  always @(negedge clk) begin
    logic nr;
    if (rst) begin
      nr = 1'b0;
    end else begin
      if (out_fire) begin
        if (beats_seen == 40 || beats_seen == 120) rx_hold = 300;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        nr = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
    end
    m_tready <= nr;
  end

endmodule
